/* rtl/core/wnm_pkg.sv */
package wnm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int POS_W         = $clog2(PATTERN_BYTES + 1);
    localparam int IDX_W         = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int LEN_W         = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_BIAS = 8'h20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW      = 2'd0,
        REG_PATTERN_HIGH     = 2'd1,
        REG_PATTERN_LENGTH   = 2'd2,
        REG_CASE_INSENSITIVE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pat_bytes;
        logic [POS_W-1:0]              eff_len;
        logic [PATTERN_BYTES:0]        stop_map;
        logic                          nocase;
    } pat_cfg_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic nocase);
        if (nocase && c >= LOWER_A && c <= LOWER_Z) begin
            return c - CASE_BIAS;
        end
        return c;
    endfunction

    // first position at or after pos that is not a star or lies at the pattern end
    function automatic logic [POS_W-1:0] skip_stars(input logic [POS_W-1:0] pos,
                                                    input logic [PATTERN_BYTES:0] stop_map);
        logic [POS_W-1:0] q;
        logic             found;
        q     = pos;
        found = 1'b0;
        for (int i = 0; i <= PATTERN_BYTES; i++) begin
            if (!found && i >= int'(pos) && stop_map[i]) begin
                q     = POS_W'(i);
                found = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

/* rtl/core/wnm_cfg_regs.sv */
module wnm_cfg_regs
    import wnm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output pat_cfg_t               pat_cfg
);

    logic [CFG_DATA_W-1:0] pat_low_reg,  pat_low_next;
    logic [CFG_DATA_W-1:0] pat_high_reg, pat_high_next;
    logic [LEN_W-1:0]      pat_len_reg,  pat_len_next;
    logic                  nocase_reg,   nocase_next;

    logic [PATTERN_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]              clamp_len;
    logic [POS_W-1:0]              eff_len;
    logic                          len_found;

    assign cfg_ready = 1'b1;

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        nocase_next   = nocase_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:      pat_low_next  = cfg_data;
                REG_PATTERN_HIGH:     pat_high_next = cfg_data;
                REG_PATTERN_LENGTH:   pat_len_next  = cfg_data[LEN_W-1:0];
                REG_CASE_INSENSITIVE: nocase_next   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            nocase_reg   <= 1'b0;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
            nocase_reg   <= nocase_next;
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if (i < 8) begin
                bytes[i] = pat_low_reg[8*(i%8) +: 8];
            end else begin
                bytes[i] = pat_high_reg[8*(i%8) +: 8];
            end
        end

        if (pat_len_reg > LEN_W'(PATTERN_BYTES)) begin
            clamp_len = LEN_W'(PATTERN_BYTES);
        end else begin
            clamp_len = pat_len_reg;
        end

        // a zero byte ends the pattern early
        eff_len   = POS_W'(clamp_len);
        len_found = 1'b0;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if (!len_found && (i >= int'(clamp_len) || bytes[i] == NUL_BYTE)) begin
                eff_len   = POS_W'(i);
                len_found = 1'b1;
            end
        end

        for (int i = 0; i < PATTERN_BYTES; i++) begin
            pat_cfg.stop_map[i] = (i >= int'(eff_len)) || (bytes[i] != STAR_BYTE);
        end
        pat_cfg.stop_map[PATTERN_BYTES] = 1'b1;

        pat_cfg.pat_bytes = bytes;
        pat_cfg.eff_len   = eff_len;
        pat_cfg.nocase    = nocase_reg;
    end

endmodule

/* rtl/core/wnm_step.sv */
module wnm_step
    import wnm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pat_cfg_t   pat_cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_char_reg;
    logic             in_last_reg;
    logic             in_empty_reg;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic             skip_reg, skip_next;
    logic             fail_reg, fail_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_match_reg, out_match_next;

    logic             produces;
    logic             out_free;
    logic             consume;
    logic [7:0]       c;
    logic [POS_W-1:0] p1;
    logic             sk1;
    logic [POS_W-1:0] p2;
    logic             sk2;
    logic             f2;
    logic             hit;
    logic [POS_W-1:0] q;
    logic             matched;

    assign produces = in_last_reg | in_empty_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (out_free || !produces);
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        c   = fold(in_char_reg, pat_cfg.nocase);
        p1  = pos_reg;
        sk1 = skip_reg;
        if (!skip_reg && pos_reg < pat_cfg.eff_len
                && pat_cfg.pat_bytes[pos_reg[IDX_W-1:0]] == STAR_BYTE) begin
            p1  = skip_stars(pos_reg, pat_cfg.stop_map);
            sk1 = 1'b1;
        end
        hit = (p1 < pat_cfg.eff_len)
            && (fold(pat_cfg.pat_bytes[p1[IDX_W-1:0]], pat_cfg.nocase) == c);

        p2  = p1;
        sk2 = sk1;
        f2  = 1'b0;
        if (hit) begin
            p2  = p1 + POS_W'(1);
            sk2 = 1'b0;
        end else if (!sk1) begin
            f2 = 1'b1;
        end
        if (fail_reg) begin
            p2  = pos_reg;
            sk2 = skip_reg;
            f2  = 1'b1;
        end

        q       = skip_stars(p2, pat_cfg.stop_map);
        matched = in_empty_reg || (!f2 && q >= pat_cfg.eff_len);
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end

        pos_next  = pos_reg;
        skip_next = skip_reg;
        fail_next = fail_reg;
        if (consume) begin
            if (produces) begin
                pos_next  = '0;
                skip_next = 1'b0;
                fail_next = 1'b0;
            end else begin
                pos_next  = p2;
                skip_next = sk2;
                fail_next = f2;
            end
        end

        out_valid_next = out_valid_reg;
        out_match_next = out_match_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (consume && produces) begin
            out_valid_next = 1'b1;
            out_match_next = matched;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        out_match_reg <= out_match_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};

endmodule

/* rtl/core/wildcard_name_matcher_unit.sv */
// Wildcard name matcher.
// Input stream: one name character per item on s_tdata, s_tlast marks the
// final character of a name, s_tuser marks an item that stands for a whole
// empty name (always a match). Each name yields one item on the m_ side,
// m_tdata bit 0 set when the name matched the pattern.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; index
// 0 pattern bytes 0..7, 1 pattern bytes 8..15, 2 pattern length, 3 case
// insensitive. Write only while no name item is in flight.
// A closing item passes the input register, then the match step writes its
// result into the output register.
// Throughput: one item per cycle while the receiver takes results; one compare
// and position update per character, so the input register drains each cycle.
// Reset clears the pattern, length, case flag, match position and the
// output. A stalled receiver holds the result; the input register keeps
// taking characters that close no name, and stops at the next closing item.
module wildcard_name_matcher_unit
    import wnm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // name_char
    input  logic                   s_tlast,
    input  logic                   s_tuser,   // empty_name
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata    // matched, zero padding
);

    pat_cfg_t pat_cfg;

    wnm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat_cfg   (pat_cfg)
    );

    wnm_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pat_cfg  (pat_cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/core/wnm_port_checker.sv */
module wnm_port_checker
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    a_padding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("result padding bits set");

    a_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) ##1 (!m_tvalid || m_tready)
            |=> m_tvalid && m_tdata[0])
        else $error("empty name not reported as a match");

endmodule

bind wildcard_name_matcher_unit wnm_port_checker u_port_checker (.*);
